// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by quaternion_arith_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QAU_CHECK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qau check failed");

// next-cycle implication
`define QAU_CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qau check failed");

`endif

// ----- hw/rtl/qau_pkg.sv -----
package qau_pkg;

   // components per quaternion (w, x, y, z)
   localparam int NUM_COMP = 4;

   // operation codes
   typedef enum logic [1:0] {
      CMD_MUL  = 2'd0,
      CMD_NORM = 2'd1,
      CMD_CONJ = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   // hamilton product sign table, bit i*4+j set when term j of component i is
   // subtracted; term j of component i is a[i^j] * b[j]
   localparam logic [NUM_COMP*NUM_COMP-1:0] HAM_NEG = 16'h284E;

endpackage

// ----- hw/rtl/qau_root_stage.sv -----
module qau_root_stage #(
   parameter int PW  = 68,
   parameter int RW  = 15,
   parameter int BIT = 0
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic [PW-1:0]                          ss_in,
   input  logic [qau_pkg::NUM_COMP-1:0][PW-1:0]   rhs_in,
   input  logic [qau_pkg::NUM_COMP-1:0][PW-1:0]   p_in,
   input  logic [qau_pkg::NUM_COMP-1:0][PW-1:0]   q_in,
   input  logic [qau_pkg::NUM_COMP-1:0][RW-1:0]   r_in,
   output logic [PW-1:0]                          ss_out,
   output logic [qau_pkg::NUM_COMP-1:0][PW-1:0]   rhs_out,
   output logic [qau_pkg::NUM_COMP-1:0][PW-1:0]   p_out,
   output logic [qau_pkg::NUM_COMP-1:0][PW-1:0]   q_out,
   output logic [qau_pkg::NUM_COMP-1:0][RW-1:0]   r_out
);
   import qau_pkg::*;

   logic [PW-1:0]                ss_ff;
   logic [NUM_COMP-1:0][PW-1:0]  rhs_ff, p_ff, q_ff, p_in_next, q_in_next;
   logic [NUM_COMP-1:0][RW-1:0]  r_ff, r_in_next;

   // one result bit per component: p tracks r*r*ss, q tracks r*ss
   always_comb begin
      logic [PW-1:0] cand;
      for (int c = 0; c < NUM_COMP; c++) begin
         cand = p_in[c] + (q_in[c] << (BIT + 1)) + (ss_in << (2 * BIT));
         if (cand <= rhs_in[c]) begin
            p_in_next[c] = cand;
            q_in_next[c] = q_in[c] + (ss_in << BIT);
            r_in_next[c] = r_in[c] | (RW'(1) << BIT);
         end else begin
            p_in_next[c] = p_in[c];
            q_in_next[c] = q_in[c];
            r_in_next[c] = r_in[c];
         end
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (en) begin
         ss_ff  <= ss_in;
         rhs_ff <= rhs_in;
         p_ff   <= p_in_next;
         q_ff   <= q_in_next;
         r_ff   <= r_in_next;
      end
   end

   assign ss_out  = ss_ff;
   assign rhs_out = rhs_ff;
   assign p_out   = p_ff;
   assign q_out   = q_ff;
   assign r_out   = r_ff;

endmodule

// ----- hw/rtl/quaternion_arith_unit.sv -----
// Quaternion arithmetic unit, signed fixed-point components.
// Input channel req_*: cmd plus quaternions a and b, one word per handshake
// (req_valid & req_ready). cmd selects multiply a*b (hamilton product,
// rounded to nearest and saturated), normalize a (each component divided by
// the exact norm, truncated toward zero) or conjugate a (x, y, z negated with
// saturation). The unused code returns zeros.
// Result channel rsp_*: r_w..r_z, zero_norm (normalize saw an all-zero a) and
// clipped (some component saturated), one word per accepted input, in order.
// On its way to rsp_valid the word crosses FRAC_BITS + 5 registers: input
// register, product stage, sum stage, one stage per quotient bit of the
// normalize root search (FRAC_BITS + 1 stages), output register.
// Throughput: one word per cycle; each stage has its own valid bit and the
// ready chain lets empty stages fill while the output is stalled, so req_ready
// drops only when every stage holds a word.
// Reset empties the pipeline; no results are lost or repeated under stalls.
`include "assert_macros.svh"

module quaternion_arith_unit #(
   parameter int FRAC_BITS  = 14,
   parameter int COMP_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [COMP_WIDTH-1:0] req_a_w,
   input  logic [COMP_WIDTH-1:0] req_a_x,
   input  logic [COMP_WIDTH-1:0] req_a_y,
   input  logic [COMP_WIDTH-1:0] req_a_z,
   input  logic [COMP_WIDTH-1:0] req_b_w,
   input  logic [COMP_WIDTH-1:0] req_b_x,
   input  logic [COMP_WIDTH-1:0] req_b_y,
   input  logic [COMP_WIDTH-1:0] req_b_z,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COMP_WIDTH-1:0] rsp_r_w,
   output logic [COMP_WIDTH-1:0] rsp_r_x,
   output logic [COMP_WIDTH-1:0] rsp_r_y,
   output logic [COMP_WIDTH-1:0] rsp_r_z,
   output logic                  rsp_zero_norm,
   output logic                  rsp_clipped
);
   import qau_pkg::*;

   localparam int CW    = COMP_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int PW    = 2 * CW + 2 * F + 4;
   localparam int RW    = F + 1;
   localparam int DW    = 2 * CW + 2;
   localparam int EW    = ((RW > CW) ? RW : CW) + 1;
   localparam int SIDEW = 2 + NUM_COMP * CW + NUM_COMP * DW + 1;
   localparam int NSTG  = F + 5;
   localparam int LAST  = NSTG - 1;

   localparam logic signed [DW-1:0] DMAX = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [DW-1:0] DMIN = ~DMAX;
   localparam logic [EW-1:0]        EMAX = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic [EW-1:0]        EMIN = EMAX + EW'(1);
   localparam logic [CW-1:0]        CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0]        CMIN = {1'b1, {(CW-1){1'b0}}};

   // pipeline control
   logic [NSTG-1:0] v_ff, en;

   always_comb begin
      en[LAST] = !v_ff[LAST] || rsp_ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // stage 0: input register
   cmd_type                      cmd0_ff;
   logic [NUM_COMP-1:0][CW-1:0]  a0_ff, b0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         cmd0_ff <= cmd_type'(req_cmd);
         a0_ff   <= {req_a_z, req_a_y, req_a_x, req_a_w};
         b0_ff   <= {req_b_z, req_b_y, req_b_x, req_b_w};
      end
   end

   // stage 1: all products and squares
   cmd_type                                     cmd1_ff;
   logic [NUM_COMP-1:0][CW-1:0]                 a1_ff;
   logic [NUM_COMP-1:0][NUM_COMP-1:0][2*CW-1:0] prod1_ff, prod1_in;
   logic [NUM_COMP-1:0][2*CW-2:0]               sq1_ff, sq1_in;

   always_comb begin
      logic signed [2*CW-1:0] pm;
      for (int i = 0; i < NUM_COMP; i++) begin
         for (int j = 0; j < NUM_COMP; j++) begin
            pm = $signed(a0_ff[i ^ j]) * $signed(b0_ff[j]);
            prod1_in[i][j] = pm;
         end
         pm = $signed(a0_ff[i]) * $signed(a0_ff[i]);
         sq1_in[i] = pm[2*CW-2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         cmd1_ff  <= cmd0_ff;
         a1_ff    <= a0_ff;
         prod1_ff <= prod1_in;
         sq1_ff   <= sq1_in;
      end
   end

   // stage 2: product sums with rounding, sum of squares, root targets
   logic [SIDEW-1:0]             side2_ff, side2_in;
   logic [PW-1:0]                ss2_ff, ss2_in;
   logic [NUM_COMP-1:0][PW-1:0]  rhs2_ff, rhs2_in;

   always_comb begin
      logic signed [DW-1:0]        acc;
      logic [NUM_COMP-1:0][DW-1:0] sums;
      logic                        zn;
      for (int i = 0; i < NUM_COMP; i++) begin
         acc = '0;
         acc[F-1] = 1'b1;
         for (int j = 0; j < NUM_COMP; j++) begin
            if (HAM_NEG[i*NUM_COMP+j]) begin
               acc = acc - DW'($signed(prod1_ff[i][j]));
            end else begin
               acc = acc + DW'($signed(prod1_ff[i][j]));
            end
         end
         sums[i] = acc >>> F;
      end
      ss2_in = '0;
      for (int i = 0; i < NUM_COMP; i++) begin
         ss2_in    = ss2_in + PW'(sq1_ff[i]);
         rhs2_in[i] = PW'(sq1_ff[i]) << (2 * F);
      end
      zn = (a1_ff == '0);
      side2_in = {cmd1_ff, a1_ff, sums, zn};
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         side2_ff <= side2_in;
         ss2_ff   <= ss2_in;
         rhs2_ff  <= rhs2_in;
      end
   end

   // stages 3 .. F+3: restoring root search, most significant bit first
   logic [PW-1:0]                ch_ss  [RW+1];
   logic [NUM_COMP-1:0][PW-1:0]  ch_rhs [RW+1];
   logic [NUM_COMP-1:0][PW-1:0]  ch_p   [RW+1];
   logic [NUM_COMP-1:0][PW-1:0]  ch_q   [RW+1];
   logic [NUM_COMP-1:0][RW-1:0]  ch_r   [RW+1];
   logic [SIDEW-1:0]             side_ff [RW];

   assign ch_ss[0]  = ss2_ff;
   assign ch_rhs[0] = rhs2_ff;
   assign ch_p[0]   = '0;
   assign ch_q[0]   = '0;
   assign ch_r[0]   = '0;

   for (genvar j = 0; j < RW; j++) begin : g_root
      qau_root_stage #(
         .PW  (PW),
         .RW  (RW),
         .BIT (F - j)
      ) u_stage (
         .clock   (clock),
         .en      (en[3+j]),
         .ss_in   (ch_ss[j]),
         .rhs_in  (ch_rhs[j]),
         .p_in    (ch_p[j]),
         .q_in    (ch_q[j]),
         .r_in    (ch_r[j]),
         .ss_out  (ch_ss[j+1]),
         .rhs_out (ch_rhs[j+1]),
         .p_out   (ch_p[j+1]),
         .q_out   (ch_q[j+1]),
         .r_out   (ch_r[j+1])
      );
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         side_ff[0] <= side2_ff;
      end
      for (int j = 1; j < RW; j++) begin
         if (en[3+j]) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   // output stage: select by command and saturate
   cmd_type                      out_cmd_ff;
   logic [NUM_COMP-1:0][CW-1:0]  out_r_ff, out_r_in;
   logic                         out_zn_ff, out_zn_in, out_clip_ff, out_clip_in;

   always_comb begin
      cmd_type                     s_cmd;
      logic [NUM_COMP-1:0][CW-1:0] s_a;
      logic [NUM_COMP-1:0][DW-1:0] s_sum;
      logic                        s_zn;
      logic [EW-1:0]               re, rn;
      {s_cmd, s_a, s_sum, s_zn} = side_ff[RW-1];
      out_r_in    = '0;
      out_zn_in   = 1'b0;
      out_clip_in = 1'b0;
      case (s_cmd)
         CMD_MUL: begin
            for (int i = 0; i < NUM_COMP; i++) begin
               if ($signed(s_sum[i]) > DMAX) begin
                  out_r_in[i] = CMAX;
                  out_clip_in = 1'b1;
               end else if ($signed(s_sum[i]) < DMIN) begin
                  out_r_in[i] = CMIN;
                  out_clip_in = 1'b1;
               end else begin
                  out_r_in[i] = s_sum[i][CW-1:0];
               end
            end
         end
         CMD_NORM: begin
            if (s_zn) begin
               out_zn_in = 1'b1;
            end else begin
               for (int i = 0; i < NUM_COMP; i++) begin
                  re = EW'(ch_r[RW][i]);
                  rn = EW'(0) - re;
                  if (s_a[i][CW-1]) begin
                     if (re > EMIN) begin
                        out_r_in[i] = CMIN;
                        out_clip_in = 1'b1;
                     end else begin
                        out_r_in[i] = rn[CW-1:0];
                     end
                  end else if (re > EMAX) begin
                     out_r_in[i] = CMAX;
                     out_clip_in = 1'b1;
                  end else begin
                     out_r_in[i] = re[CW-1:0];
                  end
               end
            end
         end
         CMD_CONJ: begin
            out_r_in[0] = s_a[0];
            for (int i = 1; i < NUM_COMP; i++) begin
               if (s_a[i] == CMIN) begin
                  out_r_in[i] = CMAX;
                  out_clip_in = 1'b1;
               end else begin
                  out_r_in[i] = CW'(0) - s_a[i];
               end
            end
         end
         default: begin
            out_r_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         out_cmd_ff  <= cmd_type'(side_ff[RW-1][SIDEW-1 -: 2]);
         out_r_ff    <= out_r_in;
         out_zn_ff   <= out_zn_in;
         out_clip_ff <= out_clip_in;
      end
   end

   assign rsp_r_w       = out_r_ff[0];
   assign rsp_r_x       = out_r_ff[1];
   assign rsp_r_y       = out_r_ff[2];
   assign rsp_r_z       = out_r_ff[3];
   assign rsp_zero_norm = out_zn_ff;
   assign rsp_clipped   = out_clip_ff;

   // checks
   `QAU_CHECK_IMPL(a_zero_norm_clean, clock, reset, rsp_valid && rsp_zero_norm, out_r_ff == '0 && !rsp_clipped)
   `QAU_CHECK_IMPL(a_flag_norm_only, clock, reset, rsp_valid && out_cmd_ff != CMD_NORM, !rsp_zero_norm)
   `QAU_CHECK_IMPL(a_stall_when_full, clock, reset, !req_ready, &v_ff)
   `QAU_CHECK_NEXT(a_accept_lands, clock, reset, req_valid && req_ready, v_ff[0])

endmodule
